// ----- hw/rtl/overwriting_log_ring_with_line_reads_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the overwriting log ring.
// Each macro states one clocked property with a synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef OVERWRITING_LOG_RING_WITH_LINE_READS_ASSERT_SVH
`define OVERWRITING_LOG_RING_WITH_LINE_READS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/olr_pkg.sv -----
// ---------------------------------------------------------------------------
// olr_pkg
// Types, codes and default sizes shared by the overwriting log ring.
// ---------------------------------------------------------------------------
package olr_pkg;

   // Default sizes. The ring depth must be a power of two.
   localparam int RING_BYTES_DEF  = 1024;
   localparam int NUM_READERS_DEF = 4;
   localparam int MAX_READ_DEF    = 64;

   // Byte that ends a log line.
   localparam logic [7:0] NEWLINE = 8'h0A;

   // Operation codes of a request beat.
   localparam logic [1:0] FUNC_WRITE   = 2'd0;
   localparam logic [1:0] FUNC_LINE    = 2'd1;
   localparam logic [1:0] FUNC_PEEK    = 2'd2;
   localparam logic [1:0] FUNC_ADVANCE = 2'd3;

   // One request beat.
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
      logic [1:0] reader;
      logic [6:0] max_len;
      logic       one_line;
      logic [6:0] advance_count;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [9:0] chunk_offset;
      logic [6:0] length;
      logic       has_data;
      logic       last;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CATCH,
      ST_PEEK,
      ST_SCAN_ADDR,
      ST_SCAN_DATA,
      ST_DECIDE,
      ST_EMIT_ADDR,
      ST_EMIT_DATA,
      ST_RESP
   } state_type;

endpackage

// ----- hw/rtl/olr_ring_ram.sv -----
// ---------------------------------------------------------------------------
// olr_ring_ram
// Byte storage of the log ring: one write port and one registered read port.
// ---------------------------------------------------------------------------
module olr_ring_ram #(
   parameter int DEPTH = olr_pkg::RING_BYTES_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/overwriting_log_ring_with_line_reads.sv -----
// ---------------------------------------------------------------------------
// overwriting_log_ring_with_line_reads
// Byte write and advance: a new beat every cycle while the sequencer is idle.
// Peek: catch-up, then the chunk, then the response beat; line read: catch-up,
// scan and cut of the line, then the bytes, all through the one ring read port.
// Reset clears the write and read counters; the ring bytes are not cleared.
// ---------------------------------------------------------------------------
`include "overwriting_log_ring_with_line_reads_assert.svh"

module overwriting_log_ring_with_line_reads #(
   parameter int RING_BYTES  = olr_pkg::RING_BYTES_DEF,
   parameter int NUM_READERS = olr_pkg::NUM_READERS_DEF,
   parameter int MAX_READ    = olr_pkg::MAX_READ_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  olr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output olr_pkg::rsp_type rsp_data
);

   import olr_pkg::*;

   localparam int AW = $clog2(RING_BYTES);
   localparam int RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
   localparam logic [31:0] RING32 = 32'(RING_BYTES);
   localparam logic [6:0]  MAX7   = 7'(MAX_READ);

   // Sequencer and counter state.
   state_type     state_ff, state_in;
   logic [31:0]   wcount_ff;
   logic [31:0]   rcount_ff [NUM_READERS];
   logic [1:0]    func_ff;
   logic [RW-1:0] rdr_ff;
   logic [6:0]    lim_ff;
   logic          one_ff;
   logic [AW-1:0] base_ff;
   logic [6:0]    wl_ff;
   logic [6:0]    n_ff;
   logic [6:0]    cut_ff;
   logic [6:0]    cnt_ff;
   logic [6:0]    i_ff;
   logic          resp_has_ff;
   logic [6:0]    resp_len_ff;
   logic [9:0]    resp_off_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   // Handshake and control.
   logic          req_accept;
   logic          in_range;
   logic [RW-1:0] req_ridx;
   logic [6:0]    req_lim;
   logic          out_free;
   logic          out_load;
   rsp_type       rsp_in;

   // Ring port signals.
   logic          wr_en;
   logic          rd_en;
   logic [6:0]    idx_sel;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // Catch-up, peek and decision arithmetic.
   logic [31:0]   diff;
   logic          lagging;
   logic [31:0]   avail;
   logic [31:0]   caught;
   logic [6:0]    wl_calc;
   logic [31:0]   peek_end;
   logic [6:0]    peek_len;
   logic          incomplete;
   logic [6:0]    cnt_calc;
   logic          emit_last;

   // Request decoding.
   assign req_accept = req_valid && !req_stall;
   assign req_ridx   = RW'(req_data.reader);
   assign in_range   = 32'(req_data.reader) < 32'(NUM_READERS);
   assign req_lim    = (req_data.max_len > MAX7) ? MAX7 : req_data.max_len;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Shared address adder: scan position or emit position past the base.
   assign rd_addr = AW'(32'(base_ff) + 32'(idx_sel));

   // Catch-up of the selected reader against the write counter.
   assign diff    = wcount_ff - rcount_ff[rdr_ff];
   assign lagging = diff > RING32;
   assign avail   = lagging ? RING32 : diff;
   assign caught  = lagging ? (wcount_ff - RING32) : rcount_ff[rdr_ff];
   assign wl_calc = (avail < 32'(lim_ff)) ? avail[6:0] : lim_ff;

   // Peek length stops at the ring's end.
   assign peek_end = 32'(base_ff) + 32'(wl_ff);
   assign peek_len = (peek_end > RING32) ? 7'(RING32 - 32'(base_ff)) : wl_ff;

   // Line cut once the scan is done.
   assign incomplete = (cut_ff < n_ff) && (cut_ff == 7'd0) && (n_ff < lim_ff);
   assign cnt_calc   = ((cut_ff < n_ff) && (cut_ff != 7'd0)) ? cut_ff : n_ff;
   assign emit_last  = (i_ff + 7'd1) == cnt_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.func == FUNC_LINE ||
                               req_data.func == FUNC_PEEK)) begin
               state_in = in_range ? ST_CATCH : ST_RESP;
            end
         end
         ST_CATCH: begin
            if (avail == 32'd0) begin
               state_in = ST_RESP;
            end else if (func_ff == FUNC_PEEK) begin
               state_in = ST_PEEK;
            end else begin
               state_in = ST_SCAN_ADDR;
            end
         end
         ST_PEEK: begin
            state_in = ST_RESP;
         end
         ST_SCAN_ADDR: begin
            state_in = (n_ff == wl_ff) ? ST_DECIDE : ST_SCAN_DATA;
         end
         ST_SCAN_DATA: begin
            state_in = (rd_data == NEWLINE && one_ff) ? ST_DECIDE : ST_SCAN_ADDR;
         end
         ST_DECIDE: begin
            if (incomplete || cnt_calc == 7'd0) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_EMIT_ADDR;
            end
         end
         ST_EMIT_ADDR: begin
            state_in = ST_EMIT_DATA;
         end
         ST_EMIT_DATA: begin
            if (out_free) begin
               state_in = emit_last ? ST_IDLE : ST_EMIT_ADDR;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      idx_sel   = n_ff;
      out_load  = 1'b0;
      rsp_in    = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            wr_en     = req_valid && (req_data.func == FUNC_WRITE);
         end
         ST_SCAN_ADDR: begin
            rd_en = n_ff != wl_ff;
         end
         ST_EMIT_ADDR: begin
            rd_en   = 1'b1;
            idx_sel = i_ff;
         end
         ST_EMIT_DATA: begin
            out_load        = out_free;
            rsp_in.out_byte = rd_data;
            rsp_in.length   = cnt_ff;
            rsp_in.has_data = 1'b1;
            rsp_in.last     = emit_last;
         end
         ST_RESP: begin
            out_load            = out_free;
            rsp_in.chunk_offset = resp_off_ff;
            rsp_in.length       = resp_len_ff;
            rsp_in.has_data     = resp_has_ff;
            rsp_in.last         = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Counters, sequencer registers and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < NUM_READERS; r++) begin
            rcount_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;

         // The response register holds until its beat is taken.
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  func_ff     <= req_data.func;
                  rdr_ff      <= req_ridx;
                  lim_ff      <= req_lim;
                  one_ff      <= req_data.one_line;
                  resp_has_ff <= 1'b0;
                  resp_len_ff <= '0;
                  resp_off_ff <= '0;
                  if (req_data.func == FUNC_WRITE) begin
                     wcount_ff <= wcount_ff + 32'd1;
                  end else if (req_data.func == FUNC_ADVANCE && in_range) begin
                     rcount_ff[req_ridx] <= rcount_ff[req_ridx] +
                                            32'(req_data.advance_count);
                  end
               end
            end
            ST_CATCH: begin
               rcount_ff[rdr_ff] <= caught;
               base_ff           <= caught[AW-1:0];
               wl_ff             <= wl_calc;
               n_ff              <= '0;
               cut_ff            <= '0;
            end
            ST_PEEK: begin
               resp_has_ff <= 1'b1;
               resp_len_ff <= peek_len;
               resp_off_ff <= 10'(base_ff);
            end
            ST_SCAN_DATA: begin
               n_ff <= n_ff + 7'd1;
               if (rd_data == NEWLINE) begin
                  cut_ff <= n_ff + 7'd1;
               end
            end
            ST_DECIDE: begin
               cnt_ff      <= cnt_calc;
               i_ff        <= '0;
               resp_has_ff <= !incomplete;
               if (!incomplete) begin
                  rcount_ff[rdr_ff] <= rcount_ff[rdr_ff] + 32'(cnt_calc);
               end
            end
            ST_EMIT_DATA: begin
               if (out_free) begin
                  i_ff <= i_ff + 7'd1;
               end
            end
            default: begin
               func_ff <= func_ff;
            end
         endcase
      end
   end

   // Ring storage.
   olr_ring_ram #(
      .DEPTH (RING_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wcount_ff[AW-1:0]),
      .wr_data (req_data.data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new beat is loaded only when the response register is free.
   `OLR_ASSERT_SAME(a_load_free, clock, reset, out_load, !(rsp_valid_ff && rsp_stall), "response overwritten while stalled")

   // Emission never runs past the cut count.
   `OLR_ASSERT_SAME(a_emit_bound, clock, reset, state_ff == ST_EMIT_DATA, i_ff < cnt_ff, "emit index past line length")

   // The scan stays within the available bytes.
   `OLR_ASSERT_SAME(a_scan_bound, clock, reset, state_ff == ST_SCAN_ADDR || state_ff == ST_SCAN_DATA, n_ff <= wl_ff, "scan past limit")

   // After catch-up the reader lags the writer by at most one ring.
   `OLR_ASSERT_SAME(a_caught_up, clock, reset, state_ff == ST_SCAN_ADDR, (wcount_ff - rcount_ff[rdr_ff]) <= RING32, "reader not caught up")

   // An accepted write beat bumps the write counter by one.
   `OLR_ASSERT_NEXT(a_write_count, clock, reset, req_accept && req_data.func == FUNC_WRITE, wcount_ff == $past(wcount_ff) + 32'd1, "write counter not advanced")

endmodule

// ----- bench/overwriting_log_ring_with_line_reads_tb.sv -----
// ---------------------------------------------------------------------------
// overwriting_log_ring_with_line_reads_tb
// Self-checking bench for the overwriting log ring. Request beats are
// offered through a shared send task. A behavioral copy of the ring, its
// write counter and its four read counters predicts every response beat.
// A checker process compares each accepted response beat with the oldest
// predicted one. Directed tests come first, then random traffic under
// several idle patterns, and last a long receiver hold-off that backs
// up the block.
// ---------------------------------------------------------------------------
module overwriting_log_ring_with_line_reads_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import olr_pkg::*;

   localparam int RING            = RING_BYTES_DEF;
   localparam int READERS         = NUM_READERS_DEF;
   localparam int MAX_LEN         = MAX_READ_DEF;
   localparam int AW              = $clog2(RING);
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_CYCLES = 5000;
   localparam int HOLD_CYCLES     = 400;
   localparam int RANDOM_OPS      = 25;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Behavioral copy of the ring and its counters.
   logic [7:0]  ring_copy [RING];
   logic [31:0] wr_count;
   logic [31:0] rd_pos [READERS];
   rsp_type     awaited_beats [$];

   // Idle pattern and receiver hold-off control.
   int   send_idle_pct = 0;
   int   rcv_idle_pct  = 0;
   int   hold_len      = 0;
   logic hold_flip     = 1'b0;
   logic hold_seen;
   int   hold_left;

   int errors       = 0;
   int items_sent   = 0;
   int beats_seen   = 0;
   int line_reads   = 0;
   int peeks        = 0;
   int catch_ups    = 0;
   int quiet_cycles = 0;

   overwriting_log_ring_with_line_reads u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic void expect_beat(logic [7:0] b, int off, int len, logic hd,
                                       logic lst);
      rsp_type e;
      e.out_byte     = b;
      e.chunk_offset = 10'(off);
      e.length       = 7'(len);
      e.has_data     = hd;
      e.last         = lst;
      awaited_beats  = {awaited_beats, e};
   endfunction

   // Pull a reader that lags by more than the ring up to the oldest held
   // byte, and return how many bytes it has left to read.
   function automatic logic [31:0] catch_up(int rd);
      logic [31:0] avail;
      avail = wr_count - rd_pos[rd];
      if (avail > RING) begin
         rd_pos[rd] = wr_count - RING;
         avail      = RING;
         catch_ups++;
      end
      return avail;
   endfunction

   function automatic void predict_line_read(int rd, int lim, logic one);
      logic [7:0]  held [MAX_LEN];
      logic [31:0] avail;
      logic [31:0] base;
      logic [31:0] addr;
      int          n;
      int          cut;
      int          cnt;
      logic        stop;
      avail = catch_up(rd);
      base  = rd_pos[rd];
      n     = 0;
      cut   = 0;
      stop  = 1'b0;
      if (avail == 0) begin
         expect_beat(8'h00, 0, 0, 1'b0, 1'b1);
         return;
      end
      // Scan forward, remembering the end of the last complete line.
      while (!stop && n < avail && n < lim) begin
         addr    = base + n;
         held[n] = ring_copy[addr[AW-1:0]];
         n++;
         if (held[n-1] == NEWLINE) begin
            cut  = n;
            stop = one;
         end
      end
      // A partial line that still fits waits for its newline.
      if (cut == 0 && n > 0 && n < lim) begin
         expect_beat(8'h00, 0, 0, 1'b0, 1'b1);
         return;
      end
      // An over-long line goes out up to the limit; otherwise cut at the newline.
      cnt        = (cut != 0) ? cut : n;
      rd_pos[rd] = base + cnt;
      if (cnt == 0) begin
         expect_beat(8'h00, 0, 0, 1'b1, 1'b1);
         return;
      end
      for (int i = 0; i < cnt; i++)
         expect_beat(held[i], 0, cnt, 1'b1, i == cnt - 1);
   endfunction

   function automatic void predict_peek(int rd, int lim);
      logic [31:0] avail;
      int          pos;
      int          len;
      avail = catch_up(rd);
      if (avail == 0) begin
         expect_beat(8'h00, 0, 0, 1'b0, 1'b1);
         return;
      end
      // The chunk stops at the unread count, the limit or the ring's end.
      pos = rd_pos[rd][AW-1:0];
      len = lim;
      if (avail < len)
         len = avail;
      if (pos + len > RING)
         len = RING - pos;
      expect_beat(8'h00, pos, len, 1'b1, 1'b1);
   endfunction

   // Every reader code is in range with four readers, so no request takes
   // the out-of-range path.
   function automatic void apply_log_op(req_type beat);
      int lim;
      lim = (beat.max_len > MAX_LEN) ? MAX_LEN : beat.max_len;
      case (beat.func)
         FUNC_WRITE: begin
            ring_copy[wr_count[AW-1:0]] = beat.data_byte;
            wr_count++;
         end
         FUNC_LINE: begin
            line_reads++;
            predict_line_read(beat.reader, lim, beat.one_line);
         end
         FUNC_PEEK: begin
            peeks++;
            predict_peek(beat.reader, lim);
         end
         FUNC_ADVANCE: begin
            rd_pos[beat.reader] = rd_pos[beat.reader] + beat.advance_count;
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one request beat, idling first at random, and hold it until it
   // is taken. The prediction runs at the accepting edge.
   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      apply_log_op(beat);
      items_sent++;
   endtask

   // Fields that an operation ignores carry random noise.
   task automatic write_beat(input logic [7:0] data);
      req_type b;
      b           = req_type'($urandom);
      b.func      = FUNC_WRITE;
      b.data_byte = data;
      send_beat(b);
   endtask

   task automatic line_beat(input int rd, input int lim, input logic one);
      req_type b;
      b          = req_type'($urandom);
      b.func     = FUNC_LINE;
      b.reader   = 2'(rd);
      b.max_len  = 7'(lim);
      b.one_line = one;
      send_beat(b);
   endtask

   task automatic peek_beat(input int rd, input int lim);
      req_type b;
      b         = req_type'($urandom);
      b.func    = FUNC_PEEK;
      b.reader  = 2'(rd);
      b.max_len = 7'(lim);
      send_beat(b);
   endtask

   // Until the ring has been filled once, a reader is never pushed past
   // the write counter, since its catch-up would land on unwritten bytes.
   task automatic advance_beat(input int rd, input int n);
      req_type b;
      if (wr_count < RING && n > wr_count - rd_pos[rd])
         n = wr_count - rd_pos[rd];
      b               = req_type'($urandom);
      b.func          = FUNC_ADVANCE;
      b.reader        = 2'(rd);
      b.advance_count = 7'(n);
      send_beat(b);
   endtask

   task automatic write_text(input string s);
      for (int i = 0; i < s.len(); i++)
         write_beat(s[i]);
   endtask

   // Mostly printable log text with frequent newlines and some raw bytes.
   function automatic logic [7:0] text_byte();
      int p;
      p = $urandom_range(99);
      if (p < 10)
         return NEWLINE;
      if (p < 20)
         return 8'($urandom_range(255));
      return 8'($urandom_range(126, 32));
   endfunction

   task automatic random_log_op();
      int p;
      int rd;
      int lim;
      p   = $urandom_range(99);
      rd  = $urandom_range(READERS - 1);
      lim = ($urandom_range(9) == 0) ? $urandom_range(127, MAX_LEN + 1)
                                     : $urandom_range(MAX_LEN);
      if (p < 55)
         write_beat(text_byte());
      else if (p < 80)
         line_beat(rd, lim, 1'($urandom_range(1)));
      else if (p < 90)
         peek_beat(rd, lim);
      else if ($urandom_range(3) == 0)
         advance_beat(rd, $urandom_range(127));
      else
         advance_beat(rd, $urandom_range(8));
   endtask

   // Stop offering and wait for every predicted beat, then a short pause.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int rcv_pct);
      send_idle_pct <= send_pct;
      rcv_idle_pct  <= rcv_pct;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Empty readers, complete and partial lines, zero and saturated limits,
   // one-line mode, a short over-long line and extreme byte values.
   task automatic test_directed_reads();
      peek_beat(0, 64);
      line_beat(1, 64, 1'b0);
      write_text("ab\n");
      line_beat(0, 64, 1'b0);
      write_text("cd");
      line_beat(0, 64, 1'b0);
      peek_beat(0, 64);
      line_beat(0, 0, 1'b0);
      peek_beat(0, 0);
      write_text("\n");
      line_beat(1, 127, 1'b1);
      line_beat(1, 64, 1'b0);
      advance_beat(2, 4);
      line_beat(2, 64, 1'b0);
      line_beat(3, 2, 1'b0);
      write_beat(8'hFF);
      write_beat(8'h00);
      line_beat(0, 64, 1'b0);
      advance_beat(3, 0);
      wait_for_results();
   endtask

   // Lines longer than the limit and several lines in one read.
   task automatic test_long_lines();
      repeat (24) write_beat(8'(65 + $urandom_range(25)));
      line_beat(0, 20, 1'b0);
      write_text("one\ntwo\nthree\n");
      line_beat(0, 64, 1'b0);
      line_beat(2, 64, 1'b1);
      line_beat(2, 127, 1'b0);
      peek_beat(1, 100);
      line_beat(1, 64, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int send_pct, input int rcv_pct);
      set_idling(send_pct, rcv_pct);
      repeat (RANDOM_OPS) random_log_op();
      wait_for_results();
   endtask

   // The receiver holds off while requests keep coming, so the block
   // fills and stalls its input; afterwards the sender waits for all.
   task automatic test_backpressure();
      set_idling(0, 0);
      hold_len  <= HOLD_CYCLES;
      hold_flip <= ~hold_flip;
      write_text("held back line\n");
      repeat (12) begin
         line_beat($urandom_range(READERS - 1), $urandom_range(MAX_LEN), 1'b0);
         write_beat(text_byte());
      end
      wait_for_results();
   endtask

   // ------------------------------------------------------------------
   // Response side: stall pattern, hold-off counter and checker
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= hold_flip;
      end else if (hold_flip != hold_seen) begin
         hold_seen <= hold_flip;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (awaited_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected response beat %p", $time, rsp_data);
         end else begin
            want = awaited_beats.pop_front();
            if (rsp_data.out_byte !== want.out_byte ||
                rsp_data.chunk_offset !== want.chunk_offset ||
                rsp_data.length !== want.length ||
                rsp_data.has_data !== want.has_data ||
                rsp_data.last !== want.last) begin
               errors++;
               $display("%0t: response beat differs, expected %p, actual %p",
                        $time, want, rsp_data);
            end
         end
      end
   end

   // Watchdog: ends the run after a long stretch with no beat on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: no beat accepted for %0d cycles, %0d response beats pending",
                  $time, quiet_cycles, awaited_beats.size());
         $display("overwriting_log_ring_with_line_reads: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin
      wr_count = '0;
      foreach (rd_pos[i])
         rd_pos[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(6, 56);
      test_directed_reads();
      test_long_lines();
      test_random_traffic(6, 56);
      test_random_traffic(56, 6);
      test_random_traffic(0, 0);
      test_backpressure();
      if (awaited_beats.size() != 0) begin
         errors++;
         $display("%0t: %0d response beats never arrived", $time, awaited_beats.size());
      end
      $display("Covered %0d request beats: %0d line reads, %0d peeks, %0d reader catch-ups.",
               items_sent, line_reads, peeks, catch_ups);
      $display("Checked %0d response beats with %0d errors.", beats_seen, errors);
      if (errors == 0)
         $display("overwriting_log_ring_with_line_reads: match");
      else
         $display("overwriting_log_ring_with_line_reads: mismatch");
      $finish;
   end

endmodule
